// ----- hdl/fomm_pkg.sv -----
// shared constants and tables for the field oriented mecanum mixer
package fomm_pkg;

	localparam int DATA_WIDTH_DEF  = 16;
	localparam int ANGLE_WIDTH_DEF = 16;
	localparam int CORDIC_STEPS    = 16;
	localparam int CORDIC_GUARD    = 8;
	localparam int Z_WIDTH         = 34;
	localparam int GAIN_SHIFT      = 31 + CORDIC_GUARD;
	localparam logic signed [31:0] INV_GAIN_Q31 = 32'sd1304065748;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// arctangent of 2^-i in units of 2^32 per turn
	function automatic logic signed [Z_WIDTH-1:0] atan_turn32(input int i);
		logic signed [Z_WIDTH-1:0] v;
		begin
			case (i)
				0:       v = 34'sd536870912;
				1:       v = 34'sd316933406;
				2:       v = 34'sd167458907;
				3:       v = 34'sd85004756;
				4:       v = 34'sd42667331;
				5:       v = 34'sd21354465;
				6:       v = 34'sd10679838;
				7:       v = 34'sd5340245;
				8:       v = 34'sd2670163;
				9:       v = 34'sd1335087;
				10:      v = 34'sd667544;
				11:      v = 34'sd333772;
				12:      v = 34'sd166886;
				13:      v = 34'sd83443;
				14:      v = 34'sd41722;
				15:      v = 34'sd20861;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

// ----- hdl/field_oriented_mecanum_mixer.sv -----
// top level: quadrant fold, cordic chain, gain, normalize chain, wheel mix
//
//  channel | signals                                       | dir
//  --------+-----------------------------------------------+-----
//  input   | in_valid in_ready cmd_x cmd_y cmd_rot heading  | in
//          | field_oriented                                |
//  output  | out_valid out_ready wheel_front_left           | out
//          | wheel_front_right wheel_back_left wheel_back_right |
//
// one request per cycle while the output does not stall; the pipeline is made of
// the 16 cordic cells, one division cell per quotient bit and six single stages
// the whole pipeline holds while a result waits and out_ready is low
// arst_n clears only the valid flags of every stage
module field_oriented_mecanum_mixer import fomm_pkg::*; #(
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] cmd_x,
	input  logic signed [DATA_WIDTH-1:0] cmd_y,
	input  logic signed [DATA_WIDTH-1:0] cmd_rot,
	input  logic [ANGLE_WIDTH-1:0]       heading,
	input  logic                         field_oriented,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] wheel_front_left,
	output logic signed [DATA_WIDTH-1:0] wheel_front_right,
	output logic signed [DATA_WIDTH-1:0] wheel_back_left,
	output logic signed [DATA_WIDTH-1:0] wheel_back_right
);

	localparam int DW  = DATA_WIDTH;
	localparam int XW  = DW + CORDIC_GUARD + 3;
	localparam int CPW = 3 * DW + 1;
	localparam int PMW = XW + 32;
	localparam int RW  = DW + 2;
	localparam int MW  = DW + 3;
	localparam int NW  = 2 * DW + 2;
	localparam int DPW = 3 * RW + 4;
	localparam int SW  = RW + 3;
	localparam logic [MW-1:0] ONE = MW'(1) << (DW - 1);
	localparam logic signed [PMW-1:0] HALF = PMW'(1) <<< (GAIN_SHIFT - 1);

	logic en;
	assign en       = out_ready || !out_valid;
	assign in_ready = en;

	// ---------------- input stage: quadrant fold ----------------
	logic [ANGLE_WIDTH-1:0]    ang;
	logic [1:0]                quad;
	logic signed [XW-1:0]      xg, yg, x0_d, y0_d;
	logic signed [Z_WIDTH-1:0] z0_d;

	always_comb begin
		ang  = ~heading + ANGLE_WIDTH'(1);
		quad = ang[ANGLE_WIDTH-1 -: 2];
		xg   = XW'(cmd_x) <<< CORDIC_GUARD;
		yg   = XW'(cmd_y) <<< CORDIC_GUARD;
		z0_d = Z_WIDTH'({ang[ANGLE_WIDTH-3:0], {(34 - ANGLE_WIDTH){1'b0}}}) >>> 2;
		case (quad)
			QUAD_1: begin
				x0_d = -yg;
				y0_d = xg;
			end
			QUAD_2: begin
				x0_d = -xg;
				y0_d = -yg;
			end
			QUAD_3: begin
				x0_d = yg;
				y0_d = -xg;
			end
			default: begin
				x0_d = xg;
				y0_d = yg;
			end
		endcase
	end

	logic                      vld_s0;
	logic signed [XW-1:0]      x_s0, y_s0;
	logic signed [Z_WIDTH-1:0] z_s0;
	logic [CPW-1:0]            pass_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s0    <= x0_d;
			y_s0    <= y0_d;
			z_s0    <= z0_d;
			pass_s0 <= {field_oriented, cmd_rot, cmd_y, cmd_x};
		end
	end

	// ---------------- cordic chain ----------------
	logic                      cv   [CORDIC_STEPS+1];
	logic signed [XW-1:0]      cx   [CORDIC_STEPS+1];
	logic signed [XW-1:0]      cy   [CORDIC_STEPS+1];
	logic signed [Z_WIDTH-1:0] cz   [CORDIC_STEPS+1];
	logic [CPW-1:0]            cp   [CORDIC_STEPS+1];

	assign cv[0] = vld_s0;
	assign cx[0] = x_s0;
	assign cy[0] = y_s0;
	assign cz[0] = z_s0;
	assign cp[0] = pass_s0;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		fomm_cordic_cell #(.XW(XW), .PW(CPW), .STEP(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (cv[i]),
			.x_i    (cx[i]),
			.y_i    (cy[i]),
			.z_i    (cz[i]),
			.pass_i (cp[i]),
			.vld_o  (cv[i+1]),
			.x_o    (cx[i+1]),
			.y_o    (cy[i+1]),
			.z_o    (cz[i+1]),
			.pass_o (cp[i+1])
		);
	end

	// ---------------- gain removal ----------------
	logic                   vld_s1;
	logic signed [PMW-1:0]  px_s1, py_s1;
	logic [CPW-1:0]         pass_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cv[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= PMW'(cx[CORDIC_STEPS]) * PMW'(INV_GAIN_Q31);
			py_s1   <= PMW'(cy[CORDIC_STEPS]) * PMW'(INV_GAIN_Q31);
			pass_s1 <= cp[CORDIC_STEPS];
		end
	end

	// round half up, then select rotated or raw command
	logic signed [PMW-1:0] rxw, ryw;
	logic signed [RW-1:0]  x2_d, y2_d;
	logic                  fo_s1;
	logic signed [DW-1:0]  rawx_s1, rawy_s1, rawr_s1;

	assign {fo_s1, rawr_s1, rawy_s1, rawx_s1} = pass_s1;

	always_comb begin
		rxw = (px_s1 + HALF) >>> GAIN_SHIFT;
		ryw = (py_s1 + HALF) >>> GAIN_SHIFT;
		if (fo_s1) begin
			x2_d = rxw[RW-1:0];
			y2_d = ryw[RW-1:0];
		end else begin
			x2_d = RW'(rawx_s1);
			y2_d = RW'(rawy_s1);
		end
	end

	logic                 vld_s2;
	logic signed [RW-1:0] x_s2, y_s2, r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= x2_d;
			y_s2 <= y2_d;
			r_s2 <= RW'(rawr_s1);
		end
	end

	// ---------------- magnitude ----------------
	logic [RW-1:0] ax, ay, ar;
	logic [MW-1:0] mag_d;

	always_comb begin
		ax    = x_s2[RW-1] ? RW'(-x_s2) : RW'(x_s2);
		ay    = y_s2[RW-1] ? RW'(-y_s2) : RW'(y_s2);
		ar    = r_s2[RW-1] ? RW'(-r_s2) : RW'(r_s2);
		mag_d = MW'(ax) + MW'(ay) + MW'(ar);
	end

	logic                 vld_s3;
	logic [MW-1:0]        mag_s3;
	logic [2:0][RW-1:0]   abs_s3;
	logic signed [RW-1:0] x_s3, y_s3, r_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3 <= mag_d;
			abs_s3 <= {ar, ay, ax};
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			r_s3   <= r_s2;
		end
	end

	// ---------------- numerators ----------------
	logic                need_s4;
	logic                vld_s4;
	logic [2:0][NW-1:0]  num_s4;
	logic [MW-1:0]       mag_s4;
	logic [DPW-1:0]      pass_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				num_s4[j] <= (NW'(abs_s3[j]) << (DW - 1)) + NW'(mag_s3 >> 1);
			end
			mag_s4  <= mag_s3;
			need_s4 <= mag_s3 > ONE;
			pass_s4 <= {mag_s3 > ONE, r_s3[RW-1], y_s3[RW-1], x_s3[RW-1], r_s3, y_s3, x_s3};
		end
	end

	// ---------------- division chain ----------------
	logic               dv [DW+1];
	logic [2:0][NW-1:0] dr [DW+1];
	logic [2:0][DW-1:0] dq [DW+1];
	logic [MW-1:0]      dm [DW+1];
	logic [DPW-1:0]     dp [DW+1];

	assign dv[0] = vld_s4;
	assign dr[0] = num_s4;
	assign dq[0] = '0;
	assign dm[0] = mag_s4;
	assign dp[0] = pass_s4;

	for (genvar k = 0; k < DW; k++) begin : g_div
		fomm_div_cell #(.NW(NW), .MW(MW), .QW(DW), .PW(DPW), .STEP(DW - 1 - k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (dv[k]),
			.rem_i  (dr[k]),
			.q_i    (dq[k]),
			.mag_i  (dm[k]),
			.pass_i (dp[k]),
			.vld_o  (dv[k+1]),
			.rem_o  (dr[k+1]),
			.q_o    (dq[k+1]),
			.mag_o  (dm[k+1]),
			.pass_o (dp[k+1])
		);
	end

	// ---------------- mix and saturate ----------------
	function automatic logic signed [DW-1:0] sat_data(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] hi, lo;
		begin
			hi = SW'((2 ** (DW - 1)) - 1);
			lo = -hi - SW'(1);
			if (v > hi) begin
				return hi[DW-1:0];
			end else if (v < lo) begin
				return lo[DW-1:0];
			end
			return v[DW-1:0];
		end
	endfunction

	logic                 need_f;
	logic [2:0]           sgn_f;
	logic signed [RW-1:0] vx_f, vy_f, vr_f;
	logic signed [SW-1:0] fx, fy, fr, qs [3];

	assign {need_f, sgn_f, vr_f, vy_f, vx_f} = dp[DW];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			qs[j] = sgn_f[j] ? -SW'(dq[DW][j]) : SW'(dq[DW][j]);
		end
		fx = need_f ? qs[0] : SW'(vx_f);
		fy = need_f ? qs[1] : SW'(vy_f);
		fr = need_f ? qs[2] : SW'(vr_f);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wheel_front_left  <= sat_data(fx + fy + fr);
			wheel_front_right <= sat_data(fx - fy + fr);
			wheel_back_left   <= sat_data(-fx + fy + fr);
			wheel_back_right  <= sat_data(-fx - fy + fr);
		end
	end

	// ---------------- checks ----------------
	a_ready_follows_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (out_ready || !out_valid))
		else $error("in_ready does not follow the output stall");

	a_chain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_s4) && $stable(vld_s1) && $stable(out_valid)))
		else $error("pipeline moved while stalled");

	a_quotient_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(dv[DW] && need_f) |-> (dq[DW][0] <= (DW'(1) << (DW - 1))))
		else $error("normalized value exceeds one");

	a_need_mag: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && need_s4) |-> (mag_s4 > ONE))
		else $error("normalize flag without large magnitude");

endmodule

// ----- hdl/fomm_cordic_cell.sv -----
// one cordic micro-rotation cell with registered outputs
module fomm_cordic_cell import fomm_pkg::*; #(
	parameter int XW   = 27,
	parameter int PW   = 49,
	parameter int STEP = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vld_i,
	input  logic signed [XW-1:0]      x_i,
	input  logic signed [XW-1:0]      y_i,
	input  logic signed [Z_WIDTH-1:0] z_i,
	input  logic [PW-1:0]             pass_i,
	output logic                      vld_o,
	output logic signed [XW-1:0]      x_o,
	output logic signed [XW-1:0]      y_o,
	output logic signed [Z_WIDTH-1:0] z_o,
	output logic [PW-1:0]             pass_o
);

	localparam logic signed [Z_WIDTH-1:0] ATAN = atan_turn32(STEP);

	logic signed [XW-1:0]      dx, dy, x_d, y_d;
	logic signed [Z_WIDTH-1:0] z_d;

	always_comb begin
		dx = y_i >>> STEP;
		dy = x_i >>> STEP;
		if (!z_i[Z_WIDTH-1]) begin
			x_d = x_i - dx;
			y_d = y_i + dy;
			z_d = z_i - ATAN;
		end else begin
			x_d = x_i + dx;
			y_d = y_i - dy;
			z_d = z_i + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_o    <= x_d;
			y_o    <= y_d;
			z_o    <= z_d;
			pass_o <= pass_i;
		end
	end

endmodule

// ----- hdl/fomm_div_cell.sv -----
// one restoring division step for the three normalized lanes
module fomm_div_cell import fomm_pkg::*; #(
	parameter int NW   = 34,
	parameter int MW   = 19,
	parameter int QW   = 16,
	parameter int PW   = 56,
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_i,
	input  logic [2:0][NW-1:0]   rem_i,
	input  logic [2:0][QW-1:0]   q_i,
	input  logic [MW-1:0]        mag_i,
	input  logic [PW-1:0]        pass_i,
	output logic                 vld_o,
	output logic [2:0][NW-1:0]   rem_o,
	output logic [2:0][QW-1:0]   q_o,
	output logic [MW-1:0]        mag_o,
	output logic [PW-1:0]        pass_o
);

	logic [NW-1:0]       dv;
	logic [2:0][NW-1:0]  rem_d;
	logic [2:0][QW-1:0]  q_d;

	always_comb begin
		dv = NW'(mag_i) << STEP;
		for (int j = 0; j < 3; j++) begin
			rem_d[j] = rem_i[j];
			q_d[j]   = q_i[j];
			if (rem_i[j] >= dv) begin
				rem_d[j]     = rem_i[j] - dv;
				q_d[j][STEP] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= rem_d;
			q_o    <= q_d;
			mag_o  <= mag_i;
			pass_o <= pass_i;
		end
	end

endmodule

// ----- tb/sv/tb_field_oriented_mecanum_mixer.sv -----
// testbench for the field oriented mecanum mixer: random and directed drive requests
`timescale 1ns / 1ps

class mixer_scoreboard;
	typedef struct {
		logic signed [15:0] fl;
		logic signed [15:0] fr;
		logic signed [15:0] bl;
		logic signed [15:0] br;
	} wheel_set_t;

	wheel_set_t pending_wheels[$];
	int mismatch_count;
	int unexpected_count;

	static function longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	static function longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	static function longint scale_q15(longint v, longint mag);
		longint a;
		longint q;
		a = (v < 0) ? -v : v;
		q = (a * 32768 + mag / 2) / mag;
		return (v < 0) ? -q : q;
	endfunction

	// compute the four wheel commands for one drive request
	static function wheel_set_t mix_wheels(logic signed [15:0] cx, logic signed [15:0] cy,
		logic signed [15:0] cr, logic [15:0] hd, logic fo);
		longint atan_tab[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861};
		longint x, y, r, z, t, dx, dy, mag;
		logic [15:0] ang;
		wheel_set_t w;
		x = cx;
		y = cy;
		r = cr;
		if (fo) begin
			ang = 16'd0 - hd;
			x = x * 256;
			y = y * 256;
			z = longint'(ang[13:0]) << 16;
			case (ang[15:14])
				fomm_pkg::QUAD_1: begin t = x; x = -y; y = t; end
				fomm_pkg::QUAD_2: begin x = -x; y = -y; end
				fomm_pkg::QUAD_3: begin t = x; x = y; y = -t; end
				default: ;
			endcase
			for (int i = 0; i < 16; i++) begin
				dx = fshr(y, i);
				dy = fshr(x, i);
				if (z >= 0) begin
					x = x - dx; y = y + dy; z = z - atan_tab[i];
				end else begin
					x = x + dx; y = y - dy; z = z + atan_tab[i];
				end
			end
			x = fshr(x * 1304065748 + (longint'(1) << 38), 39);
			y = fshr(y * 1304065748 + (longint'(1) << 38), 39);
		end
		mag = ((x < 0) ? -x : x) + ((y < 0) ? -y : y) + ((r < 0) ? -r : r);
		if (mag > 32768) begin
			x = scale_q15(x, mag);
			y = scale_q15(y, mag);
			r = scale_q15(r, mag);
		end
		w.fl = 16'(clamp16(x + y + r));
		w.fr = 16'(clamp16(-(-x + y - r)));
		w.bl = 16'(clamp16(-x + y + r));
		w.br = 16'(clamp16(-(x + y - r)));
		return w;
	endfunction

	function void note_request(logic signed [15:0] cx, logic signed [15:0] cy,
		logic signed [15:0] cr, logic [15:0] hd, logic fo);
		pending_wheels.push_back(mix_wheels(cx, cy, cr, hd, fo));
	endfunction

	function void check_wheels(logic signed [15:0] fl, logic signed [15:0] fr,
		logic signed [15:0] bl, logic signed [15:0] br);
		wheel_set_t e;
		if (pending_wheels.size() == 0) begin
			unexpected_count++;
			if (mismatch_count + unexpected_count <= 10)
				$display("unexpected wheel result %0d %0d %0d %0d", fl, fr, bl, br);
			return;
		end
		e = pending_wheels.pop_front();
		if (e.fl !== fl || e.fr !== fr || e.bl !== bl || e.br !== br) begin
			mismatch_count++;
			if (mismatch_count + unexpected_count <= 10)
				$display("wheel mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
					e.fl, e.fr, e.bl, e.br, fl, fr, bl, br);
		end
	endfunction
endclass

module tb_field_oriented_mecanum_mixer;
	import fomm_pkg::*;

	localparam int RANDOM_REQUESTS = 1030;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] cmd_x = '0;
	logic signed [15:0] cmd_y = '0;
	logic signed [15:0] cmd_rot = '0;
	logic [15:0] heading = '0;
	logic field_oriented = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] wheel_front_left;
	logic signed [15:0] wheel_front_right;
	logic signed [15:0] wheel_back_left;
	logic signed [15:0] wheel_back_right;

	mixer_scoreboard wheel_board = new();
	longint cycle_count = 0;
	int hold_off_left = 0;

	field_oriented_mecanum_mixer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd_x(cmd_x), .cmd_y(cmd_y), .cmd_rot(cmd_rot),
		.heading(heading), .field_oriented(field_oriented),
		.out_valid(out_valid), .out_ready(out_ready),
		.wheel_front_left(wheel_front_left), .wheel_front_right(wheel_front_right),
		.wheel_back_left(wheel_back_left), .wheel_back_right(wheel_back_right)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic signed [15:0] pick_cmd();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(int'($urandom_range(0, 600)) - 300);
			default: return 16'($urandom);
		endcase
	endfunction

	// present one request and hold it until accepted
	task automatic send_request(logic signed [15:0] cx, logic signed [15:0] cy,
		logic signed [15:0] cr, logic [15:0] hd, logic fo);
		in_valid <= 1'b1;
		cmd_x <= cx;
		cmd_y <= cy;
		cmd_rot <= cr;
		heading <= hd;
		field_oriented <= fo;
		do @(posedge clk); while (!in_ready);
		wheel_board.note_request(cx, cy, cr, hd, fo);
	endtask

	task automatic idle_cycles(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// check and count
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && out_ready)
			wheel_board.check_wheels(wheel_front_left, wheel_front_right,
				wheel_back_left, wheel_back_right);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("field_oriented_mecanum_mixer verification failed");
			$finish;
		end
	end

	// receiver stall pattern with one long hold-off
	initial begin
		int mode;
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		out_ready <= 1'b0;
		hold_off_left = 150;
		while (hold_off_left > 0) begin
			@(posedge clk);
			hold_off_left--;
		end
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(20, 80)) begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= ($urandom_range(0, 1) != 0);
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		int burst;
		int idle_wait;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, quarter turns, normalization and saturation corners
		send_request(16'sh0000, 16'sh0000, 16'sh0000, 16'h0000, 1'b0);
		send_request(16'sh7fff, 16'sh0000, 16'sh0000, 16'h0000, 1'b0);
		send_request(16'sh8000, 16'sh8000, 16'sh8000, 16'h0000, 1'b0);
		send_request(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff, 1'b0);
		send_request(16'sh4000, 16'sh4000, 16'sh0000, 16'h0000, 1'b0);
		send_request(16'sh4000, 16'sh4001, 16'sh0000, 16'h0000, 1'b0);
		send_request(16'sh0000, 16'sh0000, 16'sh8000, 16'h0000, 1'b0);
		send_request(16'sh2000, 16'sh1000, 16'sh0800, 16'h0000, 1'b0);
		send_request(16'sh7fff, 16'sh0000, 16'sh0000, 16'h0000, 1'b1);
		send_request(16'sh7fff, 16'sh0000, 16'sh0000, 16'h4000, 1'b1);
		send_request(16'sh7fff, 16'sh0000, 16'sh0000, 16'h8000, 1'b1);
		send_request(16'sh7fff, 16'sh0000, 16'sh0000, 16'hc000, 1'b1);
		send_request(16'sh8000, 16'sh8000, 16'sh0000, 16'h2000, 1'b1);
		send_request(16'sh8000, 16'sh7fff, 16'sh7fff, 16'hffff, 1'b1);
		send_request(16'sh1234, 16'sh8000, 16'sh0100, 16'h0001, 1'b1);
		send_request(16'sh0000, 16'sh7fff, 16'sh8000, 16'h3fff, 1'b1);
		send_request(16'sh0100, 16'sh0200, 16'sh0000, 16'h5555, 1'b1);
		send_request(16'sh0000, 16'sh0000, 16'sh7fff, 16'haaaa, 1'b1);
		// random bursts; the long hold-off above fills the pipeline
		for (int n = 0; n < RANDOM_REQUESTS; ) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && n < RANDOM_REQUESTS; b++, n++)
				send_request(pick_cmd(), pick_cmd(), pick_cmd(), 16'($urandom),
					1'($urandom_range(0, 3) != 0));
			idle_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			idle_cycles(idle_wait);
		end
		in_valid <= 1'b0;
		while (wheel_board.pending_wheels.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (wheel_board.mismatch_count == 0 && wheel_board.unexpected_count == 0)
			$display("field_oriented_mecanum_mixer verification clean");
		else
			$display("field_oriented_mecanum_mixer verification failed");
		$finish;
	end
endmodule
